// File: design/bnhm_pkg.sv
package bnhm_pkg;

   localparam int CSR_W = 16;
   localparam int CSR_IDX_W = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_HB_TIMEOUT = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_VALVE_TIMEOUT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_NOMINAL_CODE = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PRESSURE_ID = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_BATTERY_ID = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_VALVE_UNKNOWN = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_VALVE_MASK = 3'd6;

   localparam logic [2:0] RPT_NONE = 3'd0;
   localparam logic [2:0] RPT_NODE_ERROR = 3'd1;
   localparam logic [2:0] RPT_ILLEGAL = 3'd2;
   localparam logic [2:0] RPT_DUP_OWNER = 3'd3;
   localparam logic [2:0] RPT_DEAD = 3'd4;

   localparam logic [2:0] MSG_STATUS = 3'd0;
   localparam logic [2:0] MSG_VALVE = 3'd1;
   localparam logic [2:0] MSG_ANALOG = 3'd2;
   localparam logic [2:0] MSG_LIVENESS = 3'd3;

   localparam logic [9:0] PRESSURE_CAP = 10'd999;
   localparam logic [3:0] LAST_EMIT_CNT = 4'd14;

   typedef struct packed {
      logic capture;
      logic msg_exec;
      logic sw_read;
      logic sw_eval;
      logic vl_read;
      logic vl_eval;
      logic emit_step;
   } cmd_type;

   typedef struct packed {
      logic idx_last;
      logic dead_none;
      logic emit_done;
   } stat_type;

endpackage

// File: design/bus_node_health_monitor.sv
// Bus node health monitor. Pulse start with busy low to hand in one item: a bus
// message (req_mode 0) or a sweep (req_mode 1). A message raises busy and yields
// one result in the cycle after its busy state. A sweep reads each node's
// last-heard time from a table with one read port, in a read state and then an
// evaluate state per node, then reads and evaluates the valve owner's entry. It
// then walks the node ids again, one per cycle, giving a result at each dead node,
// or one empty result when none died. The final result appears in the first
// cycle with busy low. Results appear on rsp_strobe for one cycle each and cannot
// be held off; rsp_last marks the final result of an item. Status fields on the
// rsp_ ports are valid whenever rsp_strobe is high. The user must write registers
// through csr_we/csr_index/csr_wdata only while busy is low; the block does not enforce this.
module bus_node_health_monitor
   import bnhm_pkg::*;
#(
   parameter int MAX_NODE_ID = 14,
   parameter int NOMINAL_LIMIT = 20
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic                 req_mode,
   input  logic [31:0]          req_now_ms,
   input  logic [4:0]           req_sender_id,
   input  logic [2:0]           req_msg_kind,
   input  logic [7:0]           req_data_two,
   input  logic [7:0]           req_data_three,
   input  logic [31:0]          req_data_tail,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata,
   output logic                 rsp_strobe,
   output logic                 rsp_last,
   output logic [2:0]           rsp_report_kind,
   output logic [4:0]           rsp_report_node,
   output logic [7:0]           rsp_report_code,
   output logic [31:0]          rsp_report_args,
   output logic [3:0]           rsp_connected_nodes,
   output logic [1:0]           rsp_valve_state,
   output logic                 rsp_errors_active,
   output logic [9:0]           rsp_tank_pressure,
   output logic [15:0]          rsp_battery_mv
);

   cmd_type cmd;
   stat_type stat;

   bnhm_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .mode  (req_mode),
      .busy  (busy),
      .cmd   (cmd),
      .stat  (stat)
   );

   bnhm_dp #(
      .MAX_NODE_ID   (MAX_NODE_ID),
      .NOMINAL_LIMIT (NOMINAL_LIMIT)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .stat                (stat),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .req_now_ms          (req_now_ms),
      .req_sender_id       (req_sender_id),
      .req_msg_kind        (req_msg_kind),
      .req_data_two        (req_data_two),
      .req_data_three      (req_data_three),
      .req_data_tail       (req_data_tail),
      .rsp_strobe          (rsp_strobe),
      .rsp_last            (rsp_last),
      .rsp_report_kind     (rsp_report_kind),
      .rsp_report_node     (rsp_report_node),
      .rsp_report_code     (rsp_report_code),
      .rsp_report_args     (rsp_report_args),
      .rsp_connected_nodes (rsp_connected_nodes),
      .rsp_valve_state     (rsp_valve_state),
      .rsp_errors_active   (rsp_errors_active),
      .rsp_tank_pressure   (rsp_tank_pressure),
      .rsp_battery_mv      (rsp_battery_mv)
   );

`ifndef SYNTH
   a_more_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_last |-> busy)
      else $error("non-final result with block idle");

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted transfer did not raise busy");

   a_none_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && (rsp_report_kind == RPT_NONE) |-> rsp_last)
      else $error("empty report not final");

   a_dead_node: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && (rsp_report_kind == RPT_DEAD) |-> (rsp_report_node != 5'd0))
      else $error("node zero reported dead");
`endif

endmodule

// File: design/bnhm_ctrl.sv
module bnhm_ctrl
   import bnhm_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   input  logic     mode,
   output logic     busy,
   output cmd_type  cmd,
   input  stat_type stat
);

   typedef enum logic [6:0] {
      ST_IDLE = 7'b0000001,
      ST_MSG  = 7'b0000010,
      ST_SWRD = 7'b0000100,
      ST_SWEV = 7'b0001000,
      ST_VLRD = 7'b0010000,
      ST_VLEV = 7'b0100000,
      ST_EMIT = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in = mode ? ST_SWRD : ST_MSG;
            end
         end
         ST_MSG: begin
            cmd.msg_exec = 1'b1;
            state_in = ST_IDLE;
         end
         ST_SWRD: begin
            cmd.sw_read = 1'b1;
            state_in = ST_SWEV;
         end
         ST_SWEV: begin
            cmd.sw_eval = 1'b1;
            state_in = stat.idx_last ? ST_VLRD : ST_SWRD;
         end
         ST_VLRD: begin
            cmd.vl_read = 1'b1;
            state_in = ST_VLEV;
         end
         ST_VLEV: begin
            cmd.vl_eval = 1'b1;
            state_in = stat.dead_none ? ST_IDLE : ST_EMIT;
         end
         ST_EMIT: begin
            cmd.emit_step = 1'b1;
            if (stat.emit_done) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

// File: design/bnhm_dp.sv
module bnhm_dp
   import bnhm_pkg::*;
#(
   parameter int MAX_NODE_ID = 14,
   parameter int NOMINAL_LIMIT = 20
) (
   input  logic             clock,
   input  logic             reset,
   input  cmd_type          cmd,
   output stat_type         stat,
   input  logic             csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0] csr_wdata,
   input  logic [31:0]      req_now_ms,
   input  logic [4:0]       req_sender_id,
   input  logic [2:0]       req_msg_kind,
   input  logic [7:0]       req_data_two,
   input  logic [7:0]       req_data_three,
   input  logic [31:0]      req_data_tail,
   output logic             rsp_strobe,
   output logic             rsp_last,
   output logic [2:0]       rsp_report_kind,
   output logic [4:0]       rsp_report_node,
   output logic [7:0]       rsp_report_code,
   output logic [31:0]      rsp_report_args,
   output logic [3:0]       rsp_connected_nodes,
   output logic [1:0]       rsp_valve_state,
   output logic             rsp_errors_active,
   output logic [9:0]       rsp_tank_pressure,
   output logic [15:0]      rsp_battery_mv
);

   localparam int NSLOT = MAX_NODE_ID + 1;
   localparam int IDW = $clog2(NSLOT);
   localparam logic [IDW-1:0] IDX_MAX = IDW'(MAX_NODE_ID);
   localparam logic [IDW-1:0] IDX_FIRST = IDW'(1);
   localparam logic [4:0] SENDER_MAX = 5'(MAX_NODE_ID);
   localparam logic [4:0] RUN_LIMIT = 5'(NOMINAL_LIMIT);

   logic [15:0] hb_to_ff, vl_to_ff;
   logic [7:0] nom_ff, psid_ff, bsid_ff;
   logic [1:0] vunk_ff;
   logic [3:0] vmask_ff;

   logic [31:0] now_ff;
   logic [4:0] sender_ff;
   logic [2:0] kind_ff;
   logic [7:0] d2_ff, d3_ff;
   logic [31:0] tail_ff;

   logic [NSLOT-1:0] seen_ff, seen_in;
   logic [4:0] run_ff [NSLOT];
   logic [IDW-1:0] owner_ff, owner_in;
   logic [1:0] valve_ff, valve_in;
   logic [3:0] conn_ff, conn_in;
   logic err_ff, err_in;
   logic [15:0] press_ff, press_in, batt_ff, batt_in;

   logic [31:0] heard_mem [NSLOT];
   logic [31:0] heard_rd_ff;
   logic [IDW-1:0] rd_addr;
   logic touch;

   logic [IDW-1:0] idx_ff, idx_in;
   logic [NSLOT-1:0] dead_ff, dead_in, dead_rem;
   logic [3:0] cnt_ff, cnt_in, ecnt_ff, ecnt_in;

   logic out_v_ff, out_v_in, out_last_ff, out_last_in;
   logic [2:0] out_kind_ff, out_kind_in;
   logic [4:0] out_node_ff, out_node_in;
   logic [7:0] out_code_ff, out_code_in;
   logic [31:0] out_args_ff, out_args_in;

   logic [IDW-1:0] sidx;
   logic any_low;
   logic run_we;
   logic [4:0] run_wd;
   logic emit_last;
   logic [31:0] age;

   assign sidx = sender_ff[IDW-1:0];
   assign age = now_ff - heard_rd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         hb_to_ff <= 16'd1000;
         vl_to_ff <= 16'd1000;
         nom_ff <= 8'd0;
         psid_ff <= 8'd0;
         bsid_ff <= 8'd1;
         vunk_ff <= 2'd2;
         vmask_ff <= 4'hF;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_HB_TIMEOUT: hb_to_ff <= csr_wdata;
            CSR_VALVE_TIMEOUT: vl_to_ff <= csr_wdata;
            CSR_NOMINAL_CODE: nom_ff <= csr_wdata[7:0];
            CSR_PRESSURE_ID: psid_ff <= csr_wdata[7:0];
            CSR_BATTERY_ID: bsid_ff <= csr_wdata[7:0];
            CSR_VALVE_UNKNOWN: vunk_ff <= csr_wdata[1:0];
            CSR_VALVE_MASK: vmask_ff <= csr_wdata[3:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         now_ff <= req_now_ms;
         sender_ff <= req_sender_id;
         kind_ff <= req_msg_kind;
         d2_ff <= req_data_two;
         d3_ff <= req_data_three;
         tail_ff <= req_data_tail;
      end
   end

   always_comb begin
      any_low = 1'b0;
      for (int i = 1; i < NSLOT; i++) begin
         if (seen_ff[i] && (run_ff[i] < RUN_LIMIT)) begin
            any_low = 1'b1;
         end
      end
   end

   always_comb begin
      rd_addr = cmd.vl_read ? owner_ff : idx_ff;
      dead_rem = dead_ff;
      dead_rem[idx_ff] = 1'b0;
      emit_last = (dead_rem == '0) || (ecnt_ff == LAST_EMIT_CNT);
   end

   always_comb begin
      seen_in = seen_ff;
      owner_in = owner_ff;
      valve_in = valve_ff;
      conn_in = conn_ff;
      err_in = err_ff;
      press_in = press_ff;
      batt_in = batt_ff;
      idx_in = idx_ff;
      dead_in = dead_ff;
      cnt_in = cnt_ff;
      ecnt_in = ecnt_ff;
      touch = 1'b0;
      run_we = 1'b0;
      run_wd = '0;
      out_v_in = 1'b0;
      out_last_in = 1'b1;
      out_kind_in = RPT_NONE;
      out_node_in = '0;
      out_code_in = '0;
      out_args_in = '0;

      if (cmd.capture) begin
         idx_in = IDX_FIRST;
         dead_in = '0;
         cnt_in = '0;
      end

      if (cmd.msg_exec) begin
         out_v_in = 1'b1;
         if (sender_ff > SENDER_MAX) begin
            out_kind_in = RPT_ILLEGAL;
            out_node_in = sender_ff;
         end else begin
            case (kind_ff)
               MSG_STATUS: begin
                  touch = 1'b1;
                  if (d3_ff == nom_ff) begin
                     if (run_ff[sidx] < RUN_LIMIT) begin
                        run_we = 1'b1;
                        run_wd = run_ff[sidx] + 5'd1;
                     end else if (!any_low) begin
                        err_in = 1'b0;
                     end
                  end else begin
                     run_we = 1'b1;
                     run_wd = '0;
                     err_in = 1'b1;
                     out_kind_in = RPT_NODE_ERROR;
                     out_node_in = sender_ff;
                     out_code_in = d3_ff;
                     out_args_in = tail_ff;
                  end
               end
               MSG_VALVE: begin
                  touch = 1'b1;
                  if ((sidx != owner_ff) && (owner_ff != '0)) begin
                     out_kind_in = RPT_DUP_OWNER;
                     out_node_in = sender_ff;
                     out_args_in = 32'(owner_ff);
                  end else if ((d3_ff > 8'd3) || !vmask_ff[d3_ff[1:0]]) begin
                     out_kind_in = RPT_ILLEGAL;
                     out_node_in = sender_ff;
                  end else begin
                     valve_in = d3_ff[1:0];
                     owner_in = sidx;
                  end
               end
               MSG_ANALOG: begin
                  touch = 1'b1;
                  if (d2_ff == psid_ff) begin
                     press_in = {d3_ff, tail_ff[31:24]};
                  end
                  if (d2_ff == bsid_ff) begin
                     batt_in = {d3_ff, tail_ff[31:24]};
                  end
               end
               MSG_LIVENESS: touch = 1'b1;
               default: ;
            endcase
         end
         if (touch) begin
            seen_in[sidx] = 1'b1;
         end
      end

      if (cmd.sw_eval) begin
         if (seen_ff[idx_ff]) begin
            if (age < 32'(hb_to_ff)) begin
               if (cnt_ff != 4'hF) begin
                  cnt_in = cnt_ff + 4'd1;
               end
            end else begin
               seen_in[idx_ff] = 1'b0;
               dead_in[idx_ff] = 1'b1;
            end
         end
         if (idx_ff != IDX_MAX) begin
            idx_in = idx_ff + IDX_FIRST;
         end
      end

      if (cmd.vl_eval) begin
         conn_in = cnt_ff;
         idx_in = IDX_FIRST;
         ecnt_in = '0;
         if ((owner_ff == '0) || !seen_ff[owner_ff] || (age >= 32'(vl_to_ff))) begin
            valve_in = vunk_ff;
         end
         if (dead_ff == '0) begin
            out_v_in = 1'b1;
         end
      end

      if (cmd.emit_step) begin
         if (dead_ff[idx_ff]) begin
            out_v_in = 1'b1;
            out_last_in = emit_last;
            out_kind_in = RPT_DEAD;
            out_node_in = 5'(idx_ff);
            dead_in = dead_rem;
            ecnt_in = ecnt_ff + 4'd1;
         end
         if (idx_ff != IDX_MAX) begin
            idx_in = idx_ff + IDX_FIRST;
         end
      end
   end

   assign stat.idx_last = (idx_ff == IDX_MAX);
   assign stat.dead_none = (dead_ff == '0);
   assign stat.emit_done = (idx_ff == IDX_MAX) || (dead_ff[idx_ff] && emit_last);

   always_ff @(posedge clock) begin
      if (touch) begin
         heard_mem[sidx] <= now_ff;
      end
      heard_rd_ff <= heard_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NSLOT; i++) begin
            run_ff[i] <= '0;
         end
      end else if (run_we) begin
         run_ff[sidx] <= run_wd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= '0;
         owner_ff <= '0;
         valve_ff <= 2'd2;
         conn_ff <= '0;
         err_ff <= 1'b0;
         press_ff <= '0;
         batt_ff <= '0;
         idx_ff <= IDX_FIRST;
         dead_ff <= '0;
         cnt_ff <= '0;
         ecnt_ff <= '0;
         out_v_ff <= 1'b0;
      end else begin
         seen_ff <= seen_in;
         owner_ff <= owner_in;
         valve_ff <= valve_in;
         conn_ff <= conn_in;
         err_ff <= err_in;
         press_ff <= press_in;
         batt_ff <= batt_in;
         idx_ff <= idx_in;
         dead_ff <= dead_in;
         cnt_ff <= cnt_in;
         ecnt_ff <= ecnt_in;
         out_v_ff <= out_v_in;
      end
   end

   always_ff @(posedge clock) begin
      out_last_ff <= out_last_in;
      out_kind_ff <= out_kind_in;
      out_node_ff <= out_node_in;
      out_code_ff <= out_code_in;
      out_args_ff <= out_args_in;
   end

   assign rsp_strobe = out_v_ff;
   assign rsp_last = out_last_ff;
   assign rsp_report_kind = out_kind_ff;
   assign rsp_report_node = out_node_ff;
   assign rsp_report_code = out_code_ff;
   assign rsp_report_args = out_args_ff;
   assign rsp_connected_nodes = conn_ff;
   assign rsp_valve_state = valve_ff;
   assign rsp_errors_active = err_ff;
   assign rsp_tank_pressure = (press_ff > 16'(PRESSURE_CAP)) ? PRESSURE_CAP : press_ff[9:0];
   assign rsp_battery_mv = batt_ff;

endmodule
